// ===== rtl/ddsc_pkg.sv =====
// Shared types, constants and control store for the display digit scan capture unit.
package ddsc_pkg;

  // Micro-operations of the line formatter
  typedef enum logic [1:0] {
    OP_SIGN  = 2'd0,
    OP_DOTQ  = 2'd1,
    OP_DIGIT = 2'd2,
    OP_PAD   = 2'd3
  } op_e;

  // One control word: operation and its 4-bit argument (digit number or slot)
  typedef struct packed {
    op_e        op;
    logic [3:0] arg;
  } uword_t;

  localparam int unsigned ProgLen  = 27;
  localparam int unsigned PcW      = 5;
  localparam int unsigned LineLen  = 19;
  localparam int unsigned CntW     = 5;
  localparam int unsigned SlotCnt  = 16;

  localparam logic [3:0] ActSubcycle = 4'd15;
  localparam logic [3:0] RestartMin  = 4'd10;  // restart when count is above this
  localparam logic [3:0] StoreMin    = 4'd6;   // store when count is at least this
  localparam logic [3:0] CountMax    = 4'd15;
  localparam logic [3:0] PointSlotLo = 4'd14;
  localparam logic [3:0] PointSlotHi = 4'd13;

  localparam logic [6:0] ChMinus = 7'h2D;
  localparam logic [6:0] ChDot   = 7'h2E;
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChSpace = 7'h20;

  // Control store: sign, then for digits 12..1 a point check and the digit,
  // a final point check for position 0, then padding to the line length.
  function automatic uword_t urom(input logic [PcW-1:0] pc);
    uword_t w;
    w.op  = OP_PAD;
    w.arg = 4'd0;
    if (pc == 5'd0) begin
      w.op = OP_SIGN;
    end else if (pc <= 5'd24) begin
      if (pc[0]) begin
        w.op  = OP_DOTQ;
        w.arg = 4'(5'd13 - ((pc + 5'd1) >> 1));   // digit 12 down to 1
      end else begin
        w.op  = OP_DIGIT;
        w.arg = 4'(pc >> 1);                      // slot 1 up to 12
      end
    end else if (pc == 5'd25) begin
      w.op  = OP_DOTQ;
      w.arg = 4'd0;
    end
    return w;
  endfunction

endpackage

// ===== rtl/display_digit_scan_capture_unit.sv =====
// An item is taken in the cycle it is offered while no line is being sent. A line's first
// character is registered once the sequencer has gone busy after the item that finishes the
// scan, when the output side is free. Throughput: one item per cycle while no line is being
// sent; a line is stepped out by the microcode sequencer (one control word per cycle, padding
// step repeats), stretched by any output stall, during which no item is taken.
// Reset: digit store, position, count and latched nibble clear; sequencer goes idle.
module display_digit_scan_capture_unit
  import ddsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [3:0] subcycle, [7:4] io_nibble
  input  logic [1:0] s_axis_tuser_i,   // [0] is_write, [1] is_idle
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic       m_axis_tlast_o    // last_char
);

  logic [3:0]      store_q [SlotCnt];
  logic [4:0]      pos_q;
  logic [3:0]      act_cnt_q;
  logic [3:0]      nib_q;
  logic            busy_q;
  logic [PcW-1:0]  pc_q;
  logic [CntW-1:0] cnt_q;
  logic            out_vld_q;
  logic [6:0]      out_ch_q;
  logic            out_last_q;

  logic       in_acc;
  logic [3:0] subcycle;
  logic [3:0] io_nibble;
  logic       is_write;
  logic       is_idle;
  logic       act;
  logic       restart;
  logic       do_store;
  logic       out_free;
  logic       step;
  uword_t     uw;
  logic [7:0] point;
  logic       emit;
  logic [6:0] emit_ch;
  logic       emit_last;

  assign subcycle  = s_axis_tdata_i[3:0];
  assign io_nibble = s_axis_tdata_i[7:4];
  assign is_write  = s_axis_tuser_i[0];
  assign is_idle   = s_axis_tuser_i[1];

  assign s_axis_tready_o = !busy_q;
  assign in_acc          = s_axis_tvalid_i && !busy_q;
  assign act             = in_acc && (subcycle == ActSubcycle) && !is_write;
  assign restart         = act && is_idle && (act_cnt_q > RestartMin) && (nib_q == 4'd0);
  assign do_store        = act && is_idle && !restart && (act_cnt_q >= StoreMin) && !pos_q[4];

  // Capture datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCnt; i++) store_q[i] <= 4'd0;
      pos_q     <= 5'd0;
      act_cnt_q <= 4'd0;
      nib_q     <= 4'd0;
    end else if (act) begin
      if (!is_idle) begin
        if (act_cnt_q != CountMax) act_cnt_q <= act_cnt_q + 4'd1;
        nib_q <= io_nibble;
      end else begin
        act_cnt_q <= 4'd0;
        if (restart) begin
          pos_q <= 5'd15;
        end else if (do_store) begin
          store_q[pos_q[3:0]] <= nib_q;
          pos_q               <= pos_q - 5'd1;
        end
      end
    end
  end

  // Microcode fetch and decode
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign step     = busy_q && out_free;
  assign uw       = urom(pc_q);
  assign point    = {4'd0, store_q[PointSlotLo]} + ({4'd0, store_q[PointSlotHi]} * 8'd10);

  always_comb begin
    emit      = 1'b0;
    emit_ch   = ChSpace;
    emit_last = 1'b0;
    case (uw.op)
      OP_SIGN: begin
        emit    = 1'b1;
        emit_ch = store_q[0][0] ? ChMinus : ChSpace;
      end
      OP_DOTQ: begin
        emit    = (point == {4'd0, uw.arg});
        emit_ch = ChDot;
      end
      OP_DIGIT: begin
        emit    = 1'b1;
        emit_ch = ChZero + {3'd0, store_q[uw.arg]};
      end
      OP_PAD: begin
        emit      = 1'b1;
        emit_last = (cnt_q == CntW'(LineLen - 1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer: step counter, character count, line start and end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      cnt_q  <= '0;
    end else if (!busy_q) begin
      if (do_store && (pos_q == 5'd0)) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
        cnt_q  <= '0;
      end
    end else if (step) begin
      if (emit) cnt_q <= cnt_q + CntW'(1);
      if (uw.op == OP_PAD) begin
        if (emit_last) busy_q <= 1'b0;
      end else begin
        pc_q <= pc_q + PcW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_ch_q   <= emit_ch;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_ch_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/ddsc_checker.sv =====
// Port-level checker for the display digit scan capture unit, with its bind.
module ddsc_checker
  import ddsc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // A stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output item changed");

  // No input is taken while a line is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken during a line");

  // Characters are space, sign, point or digit codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7] == 1'b0) &&
      ((m_axis_tdata_o[6:0] == ChSpace) || (m_axis_tdata_o[6:0] == ChMinus) ||
       (m_axis_tdata_o[6:0] == ChDot) || (m_axis_tdata_o[6:0] >= ChZero)))
    else $error("unexpected character code");

  // The last character of a line is always a space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[6:0] == ChSpace)
    else $error("line does not end in padding");

endmodule

bind display_digit_scan_capture_unit ddsc_checker u_ddsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

// ===== tb/ddsc_line_checker.sv =====
// Checker for the display digit scan capture unit: predicts display lines and compares them.
`timescale 1ns / 1ps

module ddsc_line_checker
  import ddsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,    // [3:0] subcycle, [7:4] io_nibble
  input  logic [1:0] s_tuser_i,    // [0] is_write, [1] is_idle
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,    // [6:0] char_code, [7] zero
  input  logic       m_tlast_i,    // last_char
  output int         fail_count_o,
  output int         pending_o,
  output int         lines_due_o,
  output int         chars_checked_o
);

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } disp_char_t;

  // Own copy of the scan state
  logic [3:0]        digits [SlotCnt];
  logic signed [4:0] scan_pos;
  logic [3:0]        act_cnt;
  logic [3:0]        held_nib;

  disp_char_t line_chars_q [$];

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    lines_due_o     = 0;
    chars_checked_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < 40)
      $display("%0t ns: display line mismatch, %s: got %0h, want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Format the stored digits into one 19-character line and queue it
  task automatic queue_display_line();
    logic [6:0] text [LineLen];
    int         n;
    int         point;
    disp_char_t c;
    for (int k = 0; k < LineLen; k++) text[k] = ChSpace;
    point = int'(digits[PointSlotLo]) + 10 * int'(digits[PointSlotHi]);
    text[0] = digits[0][0] ? ChMinus : ChSpace;
    n = 1;
    // digits 12 down to 1 come from slots 1 up to 12
    for (int d = 12; d > 0; d--) begin
      if (point == d) begin
        text[n] = ChDot;
        n++;
      end
      text[n] = ChZero + 7'(digits[13 - d]);
      n++;
    end
    // point at position zero trails the last digit
    if (point == 0) text[n] = ChDot;
    for (int k = 0; k < LineLen; k++) begin
      c.code = text[k];
      c.last = (k == LineLen - 1);
      line_chars_q.push_back(c);
    end
    lines_due_o++;
  endtask

  // Advance the scan state by one accepted bus cycle
  task automatic track_bus_cycle(input logic [3:0] sc, input logic wr, input logic idl,
                                 input logic [3:0] nib);
    if (sc != ActSubcycle || wr) return;
    if (!idl) begin
      if (act_cnt != CountMax) act_cnt = act_cnt + 4'd1;
      held_nib = nib;
      return;
    end
    if (act_cnt > RestartMin && held_nib == 4'd0) begin
      scan_pos = 5'sd15;
    end else if (act_cnt >= StoreMin && scan_pos >= 0) begin
      digits[scan_pos[3:0]] = held_nib;
      scan_pos = scan_pos - 5'sd1;
      if (scan_pos == -5'sd1) queue_display_line();
    end
    act_cnt = 4'd0;
  endtask

  task automatic check_char();
    disp_char_t want;
    if (line_chars_q.size() == 0) begin
      report_mismatch("character with nothing expected", int'(m_tdata_i), 0);
      return;
    end
    want = line_chars_q.pop_front();
    chars_checked_o++;
    if (m_tdata_i[6:0] !== want.code)
      report_mismatch("char_code", int'(m_tdata_i[6:0]), int'(want.code));
    if (m_tdata_i[7] !== 1'b0)
      report_mismatch("tdata pad bit", int'(m_tdata_i[7]), 0);
    if (m_tlast_i !== want.last)
      report_mismatch("last_char", int'(m_tlast_i), int'(want.last));
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SlotCnt; s++) digits[s] = 4'd0;
      scan_pos = 5'sd0;
      act_cnt  = 4'd0;
      held_nib = 4'd0;
      line_chars_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        track_bus_cycle(s_tdata_i[3:0], s_tuser_i[0], s_tuser_i[1], s_tdata_i[7:4]);
      if (m_tvalid_i && m_tready_i) check_char();
    end
    pending_o = line_chars_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the display digit scan capture unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top
  import ddsc_pkg::*;
;

  // items after which idling stops on both sides
  localparam int CalmFrom = 170;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;    // [3:0] subcycle, [7:4] io_nibble
  logic [1:0] s_tuser;    // [0] is_write, [1] is_idle
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;    // [6:0] char_code, [7] zero
  logic       m_tlast;    // last_char

  int fail_count;
  int pending;
  int lines_due;
  int chars_checked;

  int items_sent = 0;
  int scans_run  = 0;
  bit gap_on     = 1'b0;
  bit noise_on   = 1'b0;
  bit calm_phase = 1'b0;

  display_digit_scan_capture_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  ddsc_line_checker line_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tlast_i       (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .lines_due_o     (lines_due),
    .chars_checked_o (chars_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #10_000_000;
    $display("Timed out waiting for the display unit");
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [3:0] rand_nib();
    return 4'($urandom_range(0, 15));
  endfunction

  // Offer one item, with an optional burst of idle cycles first
  task automatic push_item(input logic [3:0] sc, input logic wr, input logic idl,
                           input logic [3:0] nib);
    int gap;
    if (items_sent >= CalmFrom) calm_phase = 1'b1;
    if (gap_on && !calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {nib, sc};
    s_tuser  <= {idl, wr};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Subcycle-15 read, sometimes preceded by a cycle the unit must ignore
  task automatic bus_cycle(input logic idl, input logic [3:0] nib);
    if (noise_on && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1))
        push_item(4'($urandom_range(0, 14)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand_nib());
      else
        push_item(ActSubcycle, 1'b1, 1'($urandom_range(0, 1)), rand_nib());
    end
    push_item(ActSubcycle, 1'b0, idl, nib);
  endtask

  // One display scan: restart, then 16 digits from position 15 down to 0
  task automatic run_scan();
    logic [3:0] val [SlotCnt];
    int         pt;
    int         hi;
    int         reps;
    gap_on = ($urandom_range(0, 3) != 0);
    for (int s = 0; s < SlotCnt; s++) val[s] = rand_nib();
    // mostly a point position that lands on a digit, sometimes out of range
    if ($urandom_range(0, 4) != 0) begin
      pt = $urandom_range(0, 12);
      hi = (pt >= 10) ? 1 : 0;
      val[PointSlotHi] = 4'(hi);
      val[PointSlotLo] = 4'(pt - 10 * hi);
    end
    // restart: long activity ending on a zero nibble, then idle
    reps = $urandom_range(10, 17);
    repeat (reps) bus_cycle(1'b0, rand_nib());
    bus_cycle(1'b0, 4'd0);
    bus_cycle(1'b1, rand_nib());
    for (int p = 15; p >= 0; p--) begin
      // short burst: too little activity, nothing stored
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 5)) bus_cycle(1'b0, rand_nib());
        bus_cycle(1'b1, rand_nib());
      end
      // a zero digit with a long burst restarts the scan instead
      if (val[p] == 4'd0 && $urandom_range(0, 24) == 0) reps = $urandom_range(11, 14);
      else if (val[p] == 4'd0) reps = $urandom_range(6, 10);
      else reps = $urandom_range(6, 10);
      repeat (reps - 1) bus_cycle(1'b0, rand_nib());
      bus_cycle(1'b0, val[p]);
      bus_cycle(1'b1, rand_nib());
    end
    // scan finished: further idle cycles store nothing
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(6, 9)) bus_cycle(1'b0, 4'($urandom_range(1, 15)));
      bus_cycle(1'b1, rand_nib());
    end
    scans_run++;
  endtask

  // Output side back-pressure
  initial begin : rx_pacing
    int run_len;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
      if (!calm_phase) begin
        run_len = $urandom_range(1, 18);
        repeat (run_len) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    s_tuser  = 2'd0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // ignored cycles: other subcycles and writes
    push_item(4'd0, 1'b1, 1'b1, 4'hF);
    push_item(4'd14, 1'b0, 1'b0, 4'hF);
    push_item(ActSubcycle, 1'b1, 1'b0, 4'hF);
    // idle with no activity stores nothing
    push_item(ActSubcycle, 1'b0, 1'b1, 4'hA);
    // position is 0 after reset: one store finishes the scan, minus sign, trailing point
    repeat (5) bus_cycle(1'b0, 4'hF);
    bus_cycle(1'b0, 4'h1);
    bus_cycle(1'b1, 4'h0);
    // saturating count with zero nibble restarts at position 15
    repeat (16) bus_cycle(1'b0, rand_nib());
    bus_cycle(1'b0, 4'd0);
    bus_cycle(1'b1, 4'hF);

    // hold off until the first line has drained
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // full scans; idling stops on both sides towards the end
    noise_on = 1'b1;
    while (lines_due < 2) run_scan();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d bus items over %0d scans with ignored cycles, restarts and short bursts.",
             items_sent, scans_run);
    $display("%0d display lines predicted, %0d characters checked.", lines_due, chars_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
